@@ rtl/jkv_pkg.sv @@
// Shared types, constants and helpers of the JSON key/value extractor.
package jkv_pkg;

  localparam int KEY_BYTES       = 32;
  localparam int MAX_KEY_LEN_DEF = 32;
  localparam int LEN_W           = 6;
  localparam int OUT_LEN_W       = 13;
  localparam int CFG_DATA_W      = 64;
  localparam int CFG_IDX_W       = 3;

  localparam logic [OUT_LEN_W-1:0] MAX_OUT_LEN_RST = OUT_LEN_W'(256);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_LENGTH  = 3'd0,
    REG_KEY_0_7     = 3'd1,
    REG_KEY_8_15    = 3'd2,
    REG_KEY_16_23   = 3'd3,
    REG_KEY_24_31   = 3'd4,
    REG_MAX_OUT_LEN = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [LEN_W-1:0]       key_length;
    logic [KEY_BYTES*8-1:0] key_bytes;
    logic [OUT_LEN_W-1:0]   max_out_len;
  } cfg_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } match_ctl_t;

  typedef struct packed {
    logic [7:0] value_byte;
    logic       byte_valid;
    logic       done_res;
    logic       found;
  } res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
  endfunction

endpackage

@@ rtl/jkv_if.sv @@
// Handshake channel interfaces: text input, result output, configuration writes.
interface jkv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface jkv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] value_byte;
  logic       byte_valid;
  logic       done_res;
  logic       found;

  modport source(output valid, output value_byte, output byte_valid,
                 output done_res, output found, input ready);
  modport sink(input valid, input value_byte, input byte_valid,
               input done_res, input found, output ready);
endinterface

interface jkv_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [jkv_pkg::CFG_IDX_W-1:0]      index;
  logic [jkv_pkg::CFG_DATA_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

@@ rtl/jkv_cfg_regs.sv @@
// Configuration register file: key length, key bytes and output limit.
module jkv_cfg_regs (
  input  logic            clk,
  input  logic            rst_n,
  jkv_cfg_if.sink         cfg_ch,
  output jkv_pkg::cfg_t   cfg
);

  logic [jkv_pkg::LEN_W-1:0]       key_length_r;
  logic [jkv_pkg::KEY_BYTES*8-1:0] key_bytes_r;
  logic [jkv_pkg::OUT_LEN_W-1:0]   max_out_len_r;
  logic                            wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_length_r  <= '0;
      key_bytes_r   <= '0;
      max_out_len_r <= jkv_pkg::MAX_OUT_LEN_RST;
    end else if (wr_en) begin
      case (jkv_pkg::reg_idx_t'(cfg_ch.index))
        jkv_pkg::REG_KEY_LENGTH: begin
          key_length_r <= cfg_ch.data[jkv_pkg::LEN_W-1:0];
        end
        jkv_pkg::REG_KEY_0_7: begin
          key_bytes_r[0 +: 64] <= cfg_ch.data;
        end
        jkv_pkg::REG_KEY_8_15: begin
          key_bytes_r[64 +: 64] <= cfg_ch.data;
        end
        jkv_pkg::REG_KEY_16_23: begin
          key_bytes_r[128 +: 64] <= cfg_ch.data;
        end
        jkv_pkg::REG_KEY_24_31: begin
          key_bytes_r[192 +: 64] <= cfg_ch.data;
        end
        jkv_pkg::REG_MAX_OUT_LEN: begin
          max_out_len_r <= cfg_ch.data[jkv_pkg::OUT_LEN_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign cfg.key_length  = key_length_r;
  assign cfg.key_bytes   = key_bytes_r;
  assign cfg.max_out_len = max_out_len_r;

endmodule

@@ rtl/jkv_key_match.sv @@
// Byte window of recent text and the quote-key-quote-colon pattern compare.
module jkv_key_match #(
  parameter int MAX_KEY_LEN = jkv_pkg::MAX_KEY_LEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [7:0]           text_byte,
  input  jkv_pkg::match_ctl_t  ctl,
  input  jkv_pkg::cfg_t        cfg,
  output logic                 hit
);

  localparam int WIN      = MAX_KEY_LEN + 3;
  localparam int KEY_SPAN = (MAX_KEY_LEN < jkv_pkg::KEY_BYTES) ? MAX_KEY_LEN
                                                               : jkv_pkg::KEY_BYTES;
  localparam int SH_W     = $clog2(MAX_KEY_LEN + 1);

  // Newest byte sits in the top byte lane.
  logic [WIN*8-1:0]    win_r;
  logic [WIN*8-1:0]    win_nxt;
  logic [WIN*8-1:0]    win_shift;
  logic [WIN*8-1:0]    aligned;
  logic [SH_W-1:0]     shamt;
  logic                key_ok;
  logic [KEY_SPAN-1:0] byte_ok;
  logic                tail_ok;

  assign win_shift = {text_byte, win_r[WIN*8-1:8]};

  assign key_ok = (cfg.key_length != '0) && (int'(cfg.key_length) <= KEY_SPAN);
  assign shamt  = SH_W'(MAX_KEY_LEN - int'(cfg.key_length));

  // Slide the window so the opening quote lands in byte lane 0.
  assign aligned = win_shift >> {shamt, 3'b000};

  always_comb begin
    for (int j = 0; j < KEY_SPAN; j++) begin
      byte_ok[j] = (j >= int'(cfg.key_length)) ||
                   (aligned[(j+1)*8 +: 8] == cfg.key_bytes[j*8 +: 8]);
    end
  end

  assign tail_ok = (win_shift[WIN*8-1 -: 8] == jkv_pkg::CH_COLON) &&
                   (win_shift[WIN*8-9 -: 8] == jkv_pkg::CH_QUOTE) &&
                   (aligned[7:0] == jkv_pkg::CH_QUOTE);

  assign hit = key_ok && tail_ok && (&byte_ok);

  always_comb begin
    win_nxt = win_r;
    if (ctl.clear) begin
      win_nxt = '0;
    end else if (ctl.shift) begin
      win_nxt = win_shift;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else begin
      win_r <= win_nxt;
    end
  end

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.clear |=> (win_r == '0))
    else $error("window not cleared at end of message");

endmodule

@@ rtl/jkv_value_fsm.sv @@
// Message phase tracking, value byte emission and the per-message done result.
module jkv_value_fsm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [7:0]            text_byte,
  input  logic                  end_of_text,
  input  logic                  hit,
  input  logic [jkv_pkg::OUT_LEN_W-1:0] max_out_len,
  output jkv_pkg::match_ctl_t   ctl,
  output jkv_pkg::res_t         res,
  output logic                  has_res
);

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_SKIP,
    PH_QUOTED,
    PH_ESCAPE,
    PH_BARE,
    PH_FINISHED
  } phase_t;

  phase_t                          phase_r;
  phase_t                          phase_nxt;
  logic [jkv_pkg::OUT_LEN_W-1:0]   count_r;
  logic [jkv_pkg::OUT_LEN_W-1:0]   count_nxt;
  logic [jkv_pkg::OUT_LEN_W-1:0]   limit;
  logic                            emit_req;
  logic                            emitted;
  logic [7:0]                      emit_byte;
  logic                            last;
  logic                            shift_req;
  logic                            bare_end;

  assign limit    = (max_out_len >= jkv_pkg::OUT_LEN_W'(2))
                    ? max_out_len - jkv_pkg::OUT_LEN_W'(1) : '0;
  assign bare_end = (text_byte == jkv_pkg::CH_COMMA) ||
                    (text_byte == jkv_pkg::CH_RBRACE) ||
                    jkv_pkg::is_blank(text_byte);

  always_comb begin
    phase_nxt = phase_r;
    emit_req  = 1'b0;
    emit_byte = text_byte;
    last      = end_of_text;
    shift_req = 1'b0;
    if (text_byte == jkv_pkg::CH_NUL) begin
      // a dangling escape goes out as a plain backslash
      if (phase_r == PH_ESCAPE) begin
        emit_req  = 1'b1;
        emit_byte = jkv_pkg::CH_BSLASH;
      end
      last = 1'b1;
    end else begin
      case (phase_r)
        PH_SEARCH: begin
          shift_req = 1'b1;
          if (hit) begin
            phase_nxt = PH_SKIP;
          end
        end
        PH_SKIP: begin
          if (jkv_pkg::is_blank(text_byte)) begin
            phase_nxt = PH_SKIP;
          end else if (text_byte == jkv_pkg::CH_QUOTE) begin
            phase_nxt = PH_QUOTED;
          end else if (bare_end) begin
            phase_nxt = PH_FINISHED;
          end else begin
            phase_nxt = PH_BARE;
            emit_req  = 1'b1;
          end
        end
        PH_BARE: begin
          if (bare_end) begin
            phase_nxt = PH_FINISHED;
          end else begin
            emit_req = 1'b1;
          end
        end
        PH_QUOTED: begin
          if (text_byte == jkv_pkg::CH_QUOTE) begin
            phase_nxt = PH_FINISHED;
          end else if (text_byte == jkv_pkg::CH_BSLASH) begin
            if (end_of_text) begin
              emit_req = 1'b1;
            end else begin
              phase_nxt = PH_ESCAPE;
            end
          end else begin
            emit_req = 1'b1;
          end
        end
        PH_ESCAPE: begin
          emit_req  = 1'b1;
          phase_nxt = PH_QUOTED;
        end
        default: begin
        end
      endcase
    end

    emitted   = emit_req && (count_r < limit);
    count_nxt = emitted ? count_r + jkv_pkg::OUT_LEN_W'(1) : count_r;

    res.value_byte = emitted ? emit_byte : 8'h00;
    res.byte_valid = emitted;
    res.done_res   = last;
    res.found      = last && (count_nxt != '0);
    has_res        = emitted || last;

    if (last) begin
      phase_nxt = PH_SEARCH;
      count_nxt = '0;
    end
  end

  assign ctl.shift = adv && shift_req;
  assign ctl.clear = adv && last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      count_r <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
    end
  end

  a_done_resets: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.done_res |=> (phase_r == PH_SEARCH) && (count_r == '0))
    else $error("message state not cleared after done");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res.byte_valid && !res.done_res
      |=> count_r == $past(count_r) + jkv_pkg::OUT_LEN_W'(1))
    else $error("emitted count out of step with value bytes");

endmodule

@@ rtl/json_key_value_extractor.sv @@
// Top level: input register, extraction logic and result register.
//
//   port     dir  moves                                 accepted when
//   in_ch    in   text_byte, end_of_text                valid && ready
//   out_ch   out  value_byte, byte_valid, done_res,     valid && ready
//                 found
//   cfg_ch   in   index, data                           valid && ready
//
// One text item per cycle sustained while out_ch is not stalled; a result goes
// from the input register into the result register and waits there until taken.
// The window compare and phase logic sit between those two registers.
// Reset (synchronous, rst_n low) clears message state and loads register
// defaults; no clearing pass. cfg_ch is always ready.
// A stalled result register holds the input register, and in_ch.ready drops
// only while both are full and out_ch.ready is low.
module json_key_value_extractor #(
  parameter int MAX_KEY_LEN = jkv_pkg::MAX_KEY_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  jkv_in_if.sink    in_ch,
  jkv_out_if.source out_ch,
  jkv_cfg_if.sink   cfg_ch
);

  jkv_pkg::cfg_t       cfg;
  jkv_pkg::match_ctl_t ctl;
  jkv_pkg::res_t       res;
  jkv_pkg::res_t       res_r;
  logic                has_res;
  logic                hit;

  logic       in_vld_r;
  logic       in_vld_nxt;
  logic [7:0] byte_r;
  logic       last_r;
  logic       out_vld_r;
  logic       out_vld_nxt;
  logic       adv;
  logic       in_fire;

  assign adv          = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign in_vld_nxt  = in_fire ? 1'b1 : (adv ? 1'b0 : in_vld_r);
  assign out_vld_nxt = adv ? has_res : (out_vld_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      byte_r <= in_ch.text_byte;
      last_r <= in_ch.end_of_text;
    end
    if (adv && has_res) begin
      res_r <= res;
    end
  end

  jkv_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  jkv_key_match #(
    .MAX_KEY_LEN (MAX_KEY_LEN)
  ) u_match (
    .clk       (clk),
    .rst_n     (rst_n),
    .text_byte (byte_r),
    .ctl       (ctl),
    .cfg       (cfg),
    .hit       (hit)
  );

  jkv_value_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .text_byte   (byte_r),
    .end_of_text (last_r),
    .hit         (hit),
    .max_out_len (cfg.max_out_len),
    .ctl         (ctl),
    .res         (res),
    .has_res     (has_res)
  );

  assign out_ch.valid      = out_vld_r;
  assign out_ch.value_byte = res_r.value_byte;
  assign out_ch.byte_valid = res_r.byte_valid;
  assign out_ch.done_res   = res_r.done_res;
  assign out_ch.found      = res_r.found;

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    adv && has_res |=> out_vld_r)
    else $error("result lost on its way to the output register");

endmodule

@@ test/json_key_value_extractor_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for json_key_value_extractor: directed table, then random messages.
module json_key_value_extractor_tb;
  import jkv_pkg::*;

  localparam int WIN_LEN       = MAX_KEY_LEN_DEF + 3;
  localparam int SETTLE_CYCLES = 4;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 120;
  localparam int LONG_HOLD     = 300;
  localparam int MAX_REPORTS   = 10;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum logic [2:0] {
    SCAN_KEY, SKIP_BLANKS, IN_QUOTED, IN_ESCAPE, IN_BARE, VALUE_DONE
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } text_item_t;

  typedef struct {
    bit                   is_cfg;
    logic [CFG_IDX_W-1:0] idx;
    logic [63:0]          data;
    logic [7:0]           ch;
    logic                 eot;
    bit                   typed;
    res_t                 want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  jkv_in_if  in_ch();
  jkv_out_if out_ch();
  jkv_cfg_if cfg_ch();

  json_key_value_extractor u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and message state
  logic [LEN_W-1:0]       key_len;
  logic [KEY_BYTES*8-1:0] key_mem;
  logic [OUT_LEN_W-1:0]   out_len;
  logic [7:0]             win [WIN_LEN];
  int                     seen;
  scan_t                  scan;
  int                     emitted;

  res_t       pending_results[$];
  text_item_t msg_q[$];
  dir_row_t   dir_rows[$];
  int         mismatches;
  bit         burst;
  bit         rcv_fast;
  int         hold_cycles;

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void clear_msg();
    foreach (win[i]) win[i] = 8'h00;
    seen = 0;
    scan = SCAN_KEY;
    emitted = 0;
  endfunction

  function automatic bit key_at_tail();
    int p;
    int j;
    logic [7:0] c;
    if (key_len == 0 || key_len > MAX_KEY_LEN_DEF) return 1'b0;
    p = int'(key_len) + 3;
    if (seen < p) return 1'b0;
    for (j = 0; j < p; j++) begin
      if (j == 0 || j == p - 2) c = CH_QUOTE;
      else if (j == p - 1) c = CH_COLON;
      else c = key_mem[(j-1)*8 +: 8];
      if (win[WIN_LEN - p + j] != c) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit try_emit(input logic [7:0] c, inout res_t r);
    int lim;
    lim = (out_len >= 2) ? int'(out_len) - 1 : 0;
    if (emitted >= lim) return 1'b0;
    emitted++;
    r.value_byte = c;
    r.byte_valid = 1'b1;
    return 1'b1;
  endfunction

  // returns 1 when the byte yields a result
  function automatic bit predict_extract(input logic [7:0] c, input logic eot, output res_t r);
    bit last;
    bit sent;
    bit bare;
    int i;
    last = eot;
    sent = 1'b0;
    bare = 1'b0;
    r = '0;
    if (c == CH_NUL) begin
      if (scan == IN_ESCAPE) sent = try_emit(CH_BSLASH, r);
      last = 1'b1;
    end else begin
      case (scan)
        SCAN_KEY: begin
          for (i = 0; i < WIN_LEN - 1; i++) win[i] = win[i+1];
          win[WIN_LEN-1] = c;
          if (seen < WIN_LEN) seen++;
          if (key_at_tail()) scan = SKIP_BLANKS;
        end
        SKIP_BLANKS: begin
          if (!(c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR})) begin
            if (c == CH_QUOTE) scan = IN_QUOTED;
            else begin
              scan = IN_BARE;
              bare = 1'b1;
            end
          end
        end
        IN_BARE: bare = 1'b1;
        IN_QUOTED: begin
          if (c == CH_QUOTE) scan = VALUE_DONE;
          else if (c == CH_BSLASH && !last) scan = IN_ESCAPE;
          else sent = try_emit(c, r);
        end
        IN_ESCAPE: begin
          sent = try_emit(c, r);
          scan = IN_QUOTED;
        end
        default: ;
      endcase
      if (bare) begin
        if (c inside {CH_COMMA, CH_RBRACE, CH_SPACE, CH_TAB, CH_LF, CH_CR}) scan = VALUE_DONE;
        else sent = try_emit(c, r);
      end
    end
    if (last) begin
      r.done_res = 1'b1;
      r.found = (emitted > 0);
      clear_msg();
    end
    return last || sent;
  endfunction

  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    case (idx)
      REG_KEY_LENGTH:  key_len = data[LEN_W-1:0];
      REG_KEY_0_7:     key_mem[63:0] = data;
      REG_KEY_8_15:    key_mem[127:64] = data;
      REG_KEY_16_23:   key_mem[191:128] = data;
      REG_KEY_24_31:   key_mem[255:192] = data;
      REG_MAX_OUT_LEN: out_len = data[OUT_LEN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_cfg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_text(input logic [7:0] ch, input logic eot, input bit typed,
                           input res_t want);
    int gap;
    bit has;
    res_t r;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= ch;
    in_ch.end_of_text <= eot;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    has = predict_extract(ch, eot, r);
    if (typed) pending_results.push_back(want);
    else if (has) pending_results.push_back(r);
  endtask

  // sender pause: wait out every expected result plus pipeline latency
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input int ph);
    logic [LEN_W-1:0]     len;
    logic [OUT_LEN_W-1:0] lim;
    logic [63:0]          w;
    int                   k;
    int                   b;
    len = ($urandom_range(0, 9) < 7) ? LEN_W'($urandom_range(1, 8))
                                     : LEN_W'($urandom_range(1, MAX_KEY_LEN_DEF));
    case ($urandom_range(0, 3))
      0: lim = OUT_LEN_W'($urandom_range(2, 8));
      1: lim = MAX_OUT_LEN_RST;
      2: lim = OUT_LEN_W'(4096);
      default: lim = OUT_LEN_W'($urandom_range(0, 64));
    endcase
    case (ph)
      0: begin
        len = LEN_W'(MAX_KEY_LEN_DEF);
        lim = OUT_LEN_W'(4096);
      end
      1: begin
        len = LEN_W'(1);
        lim = OUT_LEN_W'(2);
      end
      2: len = '0;
      3: len = LEN_W'(MAX_KEY_LEN_DEF + 1);
      4: begin
        len = '1;
        lim = '1;
      end
      5: lim = '0;
      6: lim = OUT_LEN_W'(1);
      default: ;
    endcase
    for (k = 0; k < 4; k++) begin
      for (b = 0; b < 8; b++) begin
        // mostly lower-case letters, sometimes any nonzero byte
        w[b*8 +: 8] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                                  : 8'($urandom_range(8'h61, 8'h7A));
      end
      if ($urandom_range(0, 29) == 0) w[$urandom_range(0, 7)*8 +: 8] = CH_NUL;
      write_reg(CFG_IDX_W'(REG_KEY_0_7 + k), w);
    end
    w = {$urandom, $urandom};
    w[LEN_W-1:0] = len;
    write_reg(REG_KEY_LENGTH, w);
    w = {$urandom, $urandom};
    w[OUT_LEN_W-1:0] = lim;
    write_reg(REG_MAX_OUT_LEN, w);
    if (ph % 3 == 0) write_reg(REG_UNMAPPED, {$urandom, $urandom});
  endtask

  function automatic void add_byte(input logic [7:0] c);
    msg_q.push_back('{ch: c, eot: 1'b0});
  endfunction

  function automatic logic [7:0] filler();
    return ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255))
                                       : 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [7:0] any_blank();
    case ($urandom_range(0, 3))
      0: return CH_SPACE;
      1: return CH_TAB;
      2: return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  function automatic void build_message();
    int kind;
    int n;
    int k;
    int klen;
    int cut;
    logic [7:0] c;
    msg_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      // noise, with the odd zero byte
      n = $urandom_range(1, 20);
      repeat (n) add_byte(($urandom_range(0, 19) == 0) ? CH_NUL : 8'($urandom_range(1, 255)));
    end else begin
      if ($urandom_range(0, 1) == 0) add_byte("{");
      repeat ($urandom_range(0, 5)) add_byte(filler());
      klen = (key_len == 0 || key_len > MAX_KEY_LEN_DEF) ? $urandom_range(1, 4) : int'(key_len);
      add_byte(CH_QUOTE);
      for (k = 0; k < klen; k++) add_byte(key_mem[k*8 +: 8]);
      add_byte(CH_QUOTE);
      add_byte(CH_COLON);
      repeat ($urandom_range(0, 3)) add_byte(any_blank());
      if ($urandom_range(0, 1) == 0) begin
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 10);
        repeat (n) begin
          if ($urandom_range(0, 5) == 0) begin
            add_byte(CH_BSLASH);
            add_byte(8'($urandom_range(1, 255)));
          end else begin
            do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
            add_byte(c);
          end
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_QUOTE);
      end else begin
        n = $urandom_range(0, 8);
        repeat (n) begin
          do c = 8'($urandom_range(8'h21, 8'h7E)); while (c == CH_COMMA || c == CH_RBRACE);
          add_byte(c);
        end
        case ($urandom_range(0, 2))
          0: add_byte(CH_COMMA);
          1: add_byte(CH_RBRACE);
          default: add_byte(any_blank());
        endcase
      end
      repeat ($urandom_range(0, 5)) add_byte(filler());
      if (kind == 1) begin
        // broken: cut short and one byte corrupted
        cut = $urandom_range(1, msg_q.size());
        while (msg_q.size() > cut) void'(msg_q.pop_back());
        msg_q[$urandom_range(0, cut - 1)].ch = 8'($urandom_range(1, 255));
      end
    end
    if (msg_q.size() == 0) add_byte(filler());
    if ($urandom_range(0, 3) == 0) msg_q.push_back('{ch: CH_NUL, eot: 1'($urandom_range(0, 1))});
    else msg_q[msg_q.size()-1].eot = 1'b1;
  endfunction

  function automatic dir_row_t text_row(input logic [7:0] ch, input logic eot);
    dir_row_t row;
    row = '{default: '0};
    row.ch = ch;
    row.eot = eot;
    return row;
  endfunction

  function automatic dir_row_t done_row(input logic [7:0] ch, input logic eot, input logic fnd);
    dir_row_t row;
    row = text_row(ch, eot);
    row.typed = 1'b1;
    row.want = '{value_byte: 8'h00, byte_valid: 1'b0, done_res: 1'b1, found: fnd};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = data;
    return row;
  endfunction

  function automatic void add_text(input string s, input logic eot_last);
    int i;
    for (i = 0; i < s.len(); i++) dir_rows.push_back(text_row(s[i], eot_last && i == s.len() - 1));
  endfunction

  initial begin
    int ph;
    int sent;
    bit paused;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_KEY_LENGTH;
    cfg_ch.data = '0;
    mismatches = 0;
    burst = 1'b0;
    rcv_fast = 1'b0;
    hold_cycles = 0;
    key_len = '0;
    key_mem = '0;
    out_len = MAX_OUT_LEN_RST;
    clear_msg();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset registers: empty key never matches
    dir_rows.push_back(done_row(8'hFF, 1'b1, 1'b0));
    dir_rows.push_back(done_row(CH_NUL, 1'b0, 1'b0));
    dir_rows.push_back(cfg_row(REG_KEY_0_7, 64'h61));  // key "a"
    dir_rows.push_back(cfg_row(REG_KEY_LENGTH, 64'd1));
    dir_rows.push_back(cfg_row(REG_MAX_OUT_LEN, 64'd3));
    // escape pending when zero byte ends the text
    add_text("\"a\":\"\\", 1'b0);
    dir_rows.push_back(text_row(CH_NUL, 1'b0));
    // backslash as last byte of quoted value
    add_text("\"a\":\"\\", 1'b1);
    // bare value, third byte dropped by the limit
    add_text("\"a\":xyz", 1'b1);
    dir_rows.push_back(cfg_row(REG_MAX_OUT_LEN, 64'd1));
    add_text("\"a\":", 1'b0);
    dir_rows.push_back(done_row("x", 1'b1, 1'b0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_text(dir_rows[i].ch, dir_rows[i].eot, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (ph = 0; ph < PHASES; ph++) begin
      drain();
      configure(ph);
      burst = (ph % 3 == 1);
      rcv_fast = (ph % 4 == 2);
      if (ph == 3) hold_cycles = LONG_HOLD;
      sent = 0;
      paused = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_message();
        foreach (msg_q[i]) send_text(msg_q[i].ch, msg_q[i].eot, 1'b0, '0);
        sent += msg_q.size();
        if (!paused && sent >= PHASE_ITEMS / 2) begin
          drain();
          paused = 1'b1;
        end
      end
    end
    drain();

    if (mismatches == 0 && pending_results.size() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // result side ready, random stalls plus one long hold-off
  initial begin
    int n;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        n = hold_cycles;
        hold_cycles = 0;
      end else begin
        n = rcv_fast ? 0 : $urandom_range(0, 5);
      end
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected item: byte %02h valid %0b done %0b found %0b",
                             out_ch.value_byte, out_ch.byte_valid, out_ch.done_res,
                             out_ch.found));
      end else begin
        want = pending_results.pop_front();
        if (out_ch.value_byte !== want.value_byte || out_ch.byte_valid !== want.byte_valid ||
            out_ch.done_res !== want.done_res || out_ch.found !== want.found) begin
          note_error($sformatf(
            "expected byte %02h valid %0b done %0b found %0b, got %02h %0b %0b %0b",
            want.value_byte, want.byte_valid, want.done_res, want.found,
            out_ch.value_byte, out_ch.byte_valid, out_ch.done_res, out_ch.found));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
